[hdl/rotation_matrix_to_quaternion_core_defines.svh]
// Assertion macros for the rotation matrix to quaternion RTL.
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while in reset
`define RMQ_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("rmq assertion failed");
// Next-cycle implication, sampled on clk, off while in reset
`define RMQ_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("rmq assertion failed");
`else
`define RMQ_ASSERT_NOW(lbl, ant, cons)
`define RMQ_ASSERT_NEXT(lbl, ant, cons)
`endif

`endif

[hdl/rmq_pkg.sv]
// Types and constants for the rotation matrix to quaternion core.
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int unsigned ENTRY_W = 16;

    localparam logic signed [ENTRY_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [ENTRY_W-1:0] SAT_MIN = -16'sh8000;

    // One 3x3 matrix, entry mRC is row R, column C
    typedef struct packed {
        logic signed [ENTRY_W-1:0] m00;
        logic signed [ENTRY_W-1:0] m01;
        logic signed [ENTRY_W-1:0] m02;
        logic signed [ENTRY_W-1:0] m10;
        logic signed [ENTRY_W-1:0] m11;
        logic signed [ENTRY_W-1:0] m12;
        logic signed [ENTRY_W-1:0] m20;
        logic signed [ENTRY_W-1:0] m21;
        logic signed [ENTRY_W-1:0] m22;
    } matrix_t;

    // Unit quaternion plus degenerate flag
    typedef struct packed {
        logic signed [ENTRY_W-1:0] q_w;
        logic signed [ENTRY_W-1:0] q_x;
        logic signed [ENTRY_W-1:0] q_y;
        logic signed [ENTRY_W-1:0] q_z;
        logic                      degenerate;
    } quat_t;

endpackage

[hdl/rotation_matrix_to_quaternion_core.sv]
// Top level: rotation matrix to unit quaternion, fully pipelined.
//
// Takes one Q1.FRAC_BITS 3x3 rotation matrix per clock and returns the
// normalized quaternion (w,x,y,z) with the done strobe. Each matrix passes
// the input, term, square and sum registers, the square root pipeline
// (one stage per root bit), a numerator register, the four parallel
// divider lanes (one stage per quotient bit) and the output register.
// busy never rises, so a new matrix may be started on every clock;
// results come out in order, one per strobe, and must be taken in that
// cycle. A matrix with no positive radicand yields the identity
// quaternion with degenerate set.
`timescale 1ns / 1ps

`include "rotation_matrix_to_quaternion_core_defines.svh"

module rotation_matrix_to_quaternion_core
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  matrix_t matrix,
    output logic    done,
    output quat_t   result
);

    // magnitude, signed term, root, quotient and clamp widths
    localparam int MW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int VW  = MW + 1;
    localparam int RW  = MW + 1;
    localparam int SW  = 2 * RW;
    localparam int QB  = FRAC_BITS + 1;
    localparam int NW  = MW + FRAC_BITS + 1;
    localparam int EW  = ((FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17);
    localparam int SIDE_W = 4 * MW + 5;
    localparam int LAT = RW + QB + 6;

    localparam logic signed [VW-1:0] ONE_V = VW'(64'd1 << FRAC_BITS);
    localparam logic signed [ENTRY_W-1:0] ONE_Q =
        (FRAC_BITS >= 15) ? SAT_MAX : ENTRY_W'(64'd1 << FRAC_BITS);

    assign busy = 1'b0;

    // input register
    logic    in_vld_reg;
    matrix_t mat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        mat_reg <= matrix;
    end

    // trace test, leading component pick, unnormalized quaternion terms
    logic signed [VW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [VW-1:0] tr, rad;
    logic signed [VW-1:0] v_next [4];
    logic                 deg_next;
    logic                 pick1, pick2;

    always_comb
    begin
        e00 = VW'(mat_reg.m00);
        e01 = VW'(mat_reg.m01);
        e02 = VW'(mat_reg.m02);
        e10 = VW'(mat_reg.m10);
        e11 = VW'(mat_reg.m11);
        e12 = VW'(mat_reg.m12);
        e20 = VW'(mat_reg.m20);
        e21 = VW'(mat_reg.m21);
        e22 = VW'(mat_reg.m22);
        tr  = e00 + e11 + e22;
        pick1 = (e11 > e00);
        pick2 = pick1 ? (e22 > e11) : (e22 > e00);
        deg_next = 1'b0;
        rad = '0;
        if (tr > 0)
        begin
            v_next[0] = tr + ONE_V;
            v_next[1] = e21 - e12;
            v_next[2] = e02 - e20;
            v_next[3] = e10 - e01;
        end
        else if (pick2)
        begin
            rad       = e22 - e00 - e11 + ONE_V;
            v_next[0] = e10 - e01;
            v_next[1] = e02 + e20;
            v_next[2] = e12 + e21;
            v_next[3] = rad;
            deg_next  = (rad <= 0);
        end
        else if (pick1)
        begin
            rad       = e11 - e22 - e00 + ONE_V;
            v_next[0] = e02 - e20;
            v_next[1] = e01 + e10;
            v_next[2] = rad;
            v_next[3] = e21 + e12;
            deg_next  = (rad <= 0);
        end
        else
        begin
            rad       = e00 - e11 - e22 + ONE_V;
            v_next[0] = e21 - e12;
            v_next[1] = rad;
            v_next[2] = e10 + e01;
            v_next[3] = e20 + e02;
            deg_next  = (rad <= 0);
        end
    end

    logic          v_vld_reg;
    logic [MW-1:0] mag_reg [4];
    logic [3:0]    sgn_reg;
    logic          deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_vld_reg <= 1'b0;
        else
            v_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            sgn_reg[c] <= v_next[c][VW-1];
            mag_reg[c] <= MW'(v_next[c][VW-1] ? -v_next[c] : v_next[c]);
        end
        deg_reg <= deg_next;
    end

    // squares
    logic            sq_vld_reg;
    logic [2*MW-1:0] sq_reg   [4];
    logic [MW-1:0]   mag2_reg [4];
    logic [3:0]      sgn2_reg;
    logic            deg2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg <= 1'b0;
        else
            sq_vld_reg <= v_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            sq_reg[c]   <= mag_reg[c] * mag_reg[c];
            mag2_reg[c] <= mag_reg[c];
        end
        sgn2_reg <= sgn_reg;
        deg2_reg <= deg_reg;
    end

    // sum of squares
    logic              sum_vld_reg;
    logic [SW-1:0]     sum_reg;
    logic [SIDE_W-1:0] side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_vld_reg <= 1'b0;
        else
            sum_vld_reg <= sq_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]) + SW'(sq_reg[3]);
        side_reg <= {deg2_reg, sgn2_reg, mag2_reg[3], mag2_reg[2], mag2_reg[1], mag2_reg[0]};
    end

    // square root of the norm
    logic              rt_vld;
    logic [RW-1:0]     rt_root;
    logic [SIDE_W-1:0] rt_side;

    rmq_sqrt #(
        .RW     (RW),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_vld_reg),
        .radicand  (sum_reg),
        .side_in   (side_reg),
        .out_valid (rt_vld),
        .root      (rt_root),
        .side_out  (rt_side)
    );

    // numerator = mag * ONE + root/2, split into divider start remainder and low bits
    logic          prep_vld_reg;
    logic [RW-1:0] div_reg;
    logic [RW-1:0] rinit_reg [4];
    logic [QB-1:0] low_reg   [4];
    logic [3:0]    sgn3_reg;
    logic          deg3_reg;
    logic [NW-1:0] num      [4];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            num[c] = {rt_side[c*MW +: MW], {FRAC_BITS{1'b0}}, 1'b0} >> 1;
            num[c] = num[c] + NW'(rt_root >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_vld_reg <= 1'b0;
        else
            prep_vld_reg <= rt_vld;
    end

    always_ff @(posedge clk)
    begin
        div_reg <= (rt_root == '0) ? RW'(1) : rt_root;
        for (int c = 0; c < 4; c++)
        begin
            rinit_reg[c] <= RW'(num[c][NW-1:QB]);
            low_reg[c]   <= num[c][QB-1:0];
        end
        sgn3_reg <= rt_side[4*MW +: 4];
        deg3_reg <= rt_side[SIDE_W-1];
    end

    // four divider lanes; lane 0 also carries the degenerate flag
    logic [3:0]    lane_vld;
    logic [QB-1:0] lane_q   [4];
    logic [3:0]    lane_sgn;
    logic          lane_deg;

    genvar gl;
    generate
        for (gl = 0; gl < 4; gl++)
        begin : g_lane
            if (gl == 0)
            begin : g_main
                logic [1:0] sd_out;

                rmq_div #(
                    .QB     (QB),
                    .DW     (RW),
                    .SIDE_W (2)
                ) u_div (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .in_valid  (prep_vld_reg),
                    .rem_init  (rinit_reg[gl]),
                    .num_low   (low_reg[gl]),
                    .divisor   (div_reg),
                    .side_in   ({deg3_reg, sgn3_reg[gl]}),
                    .out_valid (lane_vld[gl]),
                    .quotient  (lane_q[gl]),
                    .side_out  (sd_out)
                );

                assign lane_sgn[gl] = sd_out[0];
                assign lane_deg     = sd_out[1];
            end
            else
            begin : g_other
                rmq_div #(
                    .QB     (QB),
                    .DW     (RW),
                    .SIDE_W (1)
                ) u_div (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .in_valid  (prep_vld_reg),
                    .rem_init  (rinit_reg[gl]),
                    .num_low   (low_reg[gl]),
                    .divisor   (div_reg),
                    .side_in   (sgn3_reg[gl]),
                    .out_valid (lane_vld[gl]),
                    .quotient  (lane_q[gl]),
                    .side_out  (lane_sgn[gl])
                );
            end
        end
    endgenerate

    // apply sign, saturate to 16 bits, substitute identity when degenerate
    logic signed [EW-1:0]      sval [4];
    logic signed [ENTRY_W-1:0] comp [4];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            sval[c] = EW'({1'b0, lane_q[c]});
            if (lane_sgn[c])
                sval[c] = -sval[c];
            if (sval[c] > EW'(SAT_MAX))
                comp[c] = SAT_MAX;
            else if (sval[c] < EW'(SAT_MIN))
                comp[c] = SAT_MIN;
            else
                comp[c] = ENTRY_W'(sval[c]);
        end
    end

    logic  done_reg;
    quat_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= lane_vld[0];
    end

    always_ff @(posedge clk)
    begin
        if (lane_deg)
        begin
            result_reg.q_w <= ONE_Q;
            result_reg.q_x <= '0;
            result_reg.q_y <= '0;
            result_reg.q_z <= '0;
        end
        else
        begin
            result_reg.q_w <= comp[0];
            result_reg.q_x <= comp[1];
            result_reg.q_y <= comp[2];
            result_reg.q_z <= comp[3];
        end
        result_reg.degenerate <= lane_deg;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    `RMQ_ASSERT_NOW(a_lanes_aligned, 1'b1,
        (lane_vld[0] == lane_vld[1]) && (lane_vld[0] == lane_vld[2]) &&
        (lane_vld[0] == lane_vld[3]))
    `RMQ_ASSERT_NOW(a_done_latency, done, $past(start, LAT))
    `RMQ_ASSERT_NOW(a_degenerate_identity, done && result.degenerate,
        (result.q_w == ONE_Q) && (result.q_x == '0) && (result.q_y == '0) &&
        (result.q_z == '0))

endmodule

[hdl/rmq_sqrt.sv]
// Pipelined integer square root, two radicand bits per stage, with side data.
`timescale 1ns / 1ps

module rmq_sqrt
    import rmq_pkg::*;
#(
    parameter int RW     = 34,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [2*RW-1:0]   radicand,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [RW-1:0]     root,
    output logic [SIDE_W-1:0] side_out
);

    logic              vld_reg  [RW];
    logic [RW+1:0]     rem_reg  [RW];
    logic [RW-1:0]     root_reg [RW];
    logic [2*RW-1:0]   s_reg    [RW];
    logic [SIDE_W-1:0] side_reg [RW];

    genvar g;
    generate
        for (g = 0; g < RW; g++)
        begin : g_stage
            logic              vld_in;
            logic [RW+1:0]     rem_in;
            logic [RW-1:0]     root_in;
            logic [2*RW-1:0]   s_in;
            logic [SIDE_W-1:0] side_stage;
            logic [RW+3:0]     rem_sh;
            logic [RW+3:0]     trial;
            logic [RW+1:0]     rem_next;
            logic [RW-1:0]     root_next;

            if (g == 0)
            begin : g_first
                assign vld_in     = in_valid;
                assign rem_in     = '0;
                assign root_in    = '0;
                assign s_in       = radicand;
                assign side_stage = side_in;
            end
            else
            begin : g_rest
                assign vld_in     = vld_reg[g-1];
                assign rem_in     = rem_reg[g-1];
                assign root_in    = root_reg[g-1];
                assign s_in       = s_reg[g-1];
                assign side_stage = side_reg[g-1];
            end

            // bring in the next bit pair, try subtracting 4*root+1
            always_comb
            begin
                rem_sh = {rem_in, s_in[2*RW-1 -: 2]};
                trial  = {2'b00, root_in, 2'b01};
                if (rem_sh >= trial)
                begin
                    rem_next  = (RW+2)'(rem_sh - trial);
                    root_next = {root_in[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = (RW+2)'(rem_sh);
                    root_next = {root_in[RW-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g] <= 1'b0;
                else
                    vld_reg[g] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
                s_reg[g]    <= {s_in[2*RW-3:0], 2'b00};
                side_reg[g] <= side_stage;
            end
        end
    endgenerate

    assign out_valid = vld_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

[hdl/rmq_div.sv]
// Pipelined restoring divider lane, one quotient bit per stage, with side data.
`timescale 1ns / 1ps

module rmq_div
    import rmq_pkg::*;
#(
    parameter int QB     = 15,
    parameter int DW     = 34,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DW-1:0]     rem_init,
    input  logic [QB-1:0]     num_low,
    input  logic [DW-1:0]     divisor,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [QB-1:0]     quotient,
    output logic [SIDE_W-1:0] side_out
);

    logic              vld_reg  [QB];
    logic [DW-1:0]     rem_reg  [QB];
    logic [QB-1:0]     low_reg  [QB];
    logic [QB-1:0]     q_reg    [QB];
    logic [DW-1:0]     div_reg  [QB];
    logic [SIDE_W-1:0] side_reg [QB];

    genvar g;
    generate
        for (g = 0; g < QB; g++)
        begin : g_stage
            logic              vld_in;
            logic [DW-1:0]     rem_in;
            logic [QB-1:0]     low_in;
            logic [QB-1:0]     q_in;
            logic [DW-1:0]     div_in;
            logic [SIDE_W-1:0] side_stage;
            logic [DW:0]       rem_sh;
            logic [DW-1:0]     rem_next;
            logic              q_bit;

            if (g == 0)
            begin : g_first
                assign vld_in     = in_valid;
                assign rem_in     = rem_init;
                assign low_in     = num_low;
                assign q_in       = '0;
                assign div_in     = divisor;
                assign side_stage = side_in;
            end
            else
            begin : g_rest
                assign vld_in     = vld_reg[g-1];
                assign rem_in     = rem_reg[g-1];
                assign low_in     = low_reg[g-1];
                assign q_in       = q_reg[g-1];
                assign div_in     = div_reg[g-1];
                assign side_stage = side_reg[g-1];
            end

            // shift in one numerator bit, subtract the divisor if it fits
            always_comb
            begin
                rem_sh = {rem_in, low_in[QB-1]};
                if (rem_sh >= {1'b0, div_in})
                begin
                    rem_next = DW'(rem_sh - {1'b0, div_in});
                    q_bit    = 1'b1;
                end
                else
                begin
                    rem_next = DW'(rem_sh);
                    q_bit    = 1'b0;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g] <= 1'b0;
                else
                    vld_reg[g] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[g]  <= rem_next;
                low_reg[g]  <= {low_in[QB-2:0], 1'b0};
                q_reg[g]    <= {q_in[QB-2:0], q_bit};
                div_reg[g]  <= div_in;
                side_reg[g] <= side_stage;
            end
        end
    endgenerate

    assign out_valid = vld_reg[QB-1];
    assign quotient  = q_reg[QB-1];
    assign side_out  = side_reg[QB-1];

endmodule
